FILE: rtl/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a holds on a clock edge out of reset implies b on the same edge
`define ASSERT_IMPLY(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("implication failed");

// expression must never be true out of reset
`define ASSERT_NEVER(label, clk, rst_n, a) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(a)) \
        else $error("forbidden condition seen");

`endif

FILE: rtl/sv39pte_pkg.sv
// shared types and constants of the sv39 page table engine
package sv39pte_pkg;

    localparam int unsigned ENTRIES_PER_TABLE = 512;
    localparam int unsigned VPN_W  = 9;
    localparam int unsigned PPN_W  = 44;
    localparam int unsigned PA_W   = 56;
    localparam int unsigned PTE_W  = 52;
    localparam int unsigned FLAG_W = 8;

    // command codes
    localparam logic [1:0] CMD_TRANSLATE = 2'd0;
    localparam logic [1:0] CMD_MAP       = 2'd1;
    localparam logic [1:0] CMD_UNMAP     = 2'd2;

    // status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_INVALID    = 3'd1;
    localparam logic [2:0] ST_NO_MEMORY  = 3'd2;
    localparam logic [2:0] ST_EXISTS     = 3'd3;
    localparam logic [2:0] ST_NOT_MAPPED = 3'd4;

    typedef enum logic [1:0] {
        OP_TRANSLATE,
        OP_MAP,
        OP_UNMAP,
        OP_REJECT
    } t_op;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_EVAL,
        S_ROLL
    } t_state;

    // decoded command passed from front to back
    typedef struct packed {
        t_op                op;
        logic [VPN_W-1:0]   vpn2;
        logic [VPN_W-1:0]   vpn1;
        logic [VPN_W-1:0]   vpn0;
        logic [11:0]        offset;
        logic [PPN_W-1:0]   ppn;
        logic [FLAG_W-1:0]  flags;
    } t_item;

    // back end status toward the front
    typedef struct packed {
        logic pop;
        logic clearing;
    } t_back_ctl;

endpackage

FILE: rtl/sv39pte_front.sv
// command intake, request checks and two-entry queue toward the walker
module sv39pte_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   i_command,
    input  logic [63:0]                  i_virt_addr,
    input  logic [55:0]                  i_phys_addr,
    input  logic [9:0]                   i_pte_flags,
    input  sv39pte_pkg::t_back_ctl       i_ctl,
    output logic                         o_item_valid,
    output sv39pte_pkg::t_item           o_item
);
    import sv39pte_pkg::*;

    logic   r_q_wp, r_q_rp;
    logic   [1:0] r_q_cnt, n_q_cnt;
    t_item  r_q [2];
    t_item  w_item;
    logic   w_canon, w_va_al, w_pa_al, w_flags_ok, w_push;

    // request checks
    assign w_canon    = (i_virt_addr[63:38] == '0) || (i_virt_addr[63:38] == '1);
    assign w_va_al    = (i_virt_addr[11:0] == '0);
    assign w_pa_al    = (i_phys_addr[11:0] == '0);
    assign w_flags_ok = (i_pte_flags[9:8] == 2'b00) && i_pte_flags[0]
                        && (i_pte_flags[1] || i_pte_flags[3])
                        && !(i_pte_flags[2] && !i_pte_flags[1]);

    // classify the command
    always_comb begin
        w_item.vpn2   = i_virt_addr[38:30];
        w_item.vpn1   = i_virt_addr[29:21];
        w_item.vpn0   = i_virt_addr[20:12];
        w_item.offset = i_virt_addr[11:0];
        w_item.ppn    = i_phys_addr[55:12];
        w_item.flags  = i_pte_flags[7:0];
        case (i_command)
            CMD_TRANSLATE: w_item.op = w_canon ? OP_TRANSLATE : OP_REJECT;
            CMD_MAP: begin
                w_item.op = (w_canon && w_va_al && w_pa_al && w_flags_ok) ? OP_MAP : OP_REJECT;
            end
            CMD_UNMAP: w_item.op = (w_canon && w_va_al) ? OP_UNMAP : OP_REJECT;
            default: w_item.op = OP_REJECT;
        endcase
    end

    assign busy   = (r_q_cnt == 2'd2) || i_ctl.clearing;
    assign w_push = start && !busy;

    // queue pointers and count
    always_comb begin
        n_q_cnt = r_q_cnt;
        if (w_push && !i_ctl.pop) begin
            n_q_cnt = r_q_cnt + 2'd1;
        end else if (!w_push && i_ctl.pop) begin
            n_q_cnt = r_q_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_wp  <= 1'b0;
            r_q_rp  <= 1'b0;
            r_q_cnt <= 2'd0;
        end else begin
            r_q_cnt <= n_q_cnt;
            if (w_push) begin
                r_q_wp <= !r_q_wp;
            end
            if (i_ctl.pop) begin
                r_q_rp <= !r_q_rp;
            end
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_q_wp] <= w_item;
        end
    end

    assign o_item_valid = (r_q_cnt != 2'd0);
    assign o_item       = r_q[r_q_rp];

endmodule

FILE: rtl/sv39pte_back.sv
// table walker with pte memory, bump allocator and rollback
module sv39pte_back #(
    parameter int unsigned TABLE_PAGES = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_item_valid,
    input  sv39pte_pkg::t_item           i_item,
    input  logic [43:0]                  i_base_ppn,
    output sv39pte_pkg::t_back_ctl       o_ctl,
    output logic                         o_done,
    output logic [2:0]                   o_status,
    output logic [55:0]                  o_translated_addr
);
    import sv39pte_pkg::*;

    localparam int unsigned PW = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
    localparam int unsigned AW = PW + VPN_W;
    localparam int unsigned NW = $clog2(TABLE_PAGES + 1);
    localparam int unsigned DEPTH = TABLE_PAGES * ENTRIES_PER_TABLE;

    logic [PTE_W-1:0] r_mem [DEPTH];
    logic [PTE_W-1:0] r_rdata;

    t_state r_state, n_state;
    t_item  r_item, n_item;
    logic [1:0]    r_level, n_level;
    logic [PW-1:0] r_page, n_page;
    logic [NW-1:0] r_nfp, n_nfp, r_saved, n_saved;
    logic [1:0]    r_made_v, n_made_v;
    logic [AW-1:0] r_made_slot [2];
    logic [AW-1:0] n_made_slot [2];
    logic [AW-1:0] r_clr_addr;
    logic          r_done, n_done;
    logic [2:0]    r_status, n_status;
    logic [55:0]   r_addr, n_addr;

    logic              w_we;
    logic [AW-1:0]     w_waddr, w_raddr, w_slot;
    logic [PTE_W-1:0]  w_wdata;
    logic [VPN_W-1:0]  w_vpn;
    logic              w_v, w_leaf, w_lvl_hi, w_is_map, w_link_ok, w_can_alloc, w_fail;
    logic [PPN_W-1:0]  w_child;
    logic              w_clr_last;

    // walk decode of the entry just read
    always_comb begin
        case (r_level)
            2'd2:    w_vpn = r_item.vpn2;
            2'd1:    w_vpn = r_item.vpn1;
            default: w_vpn = r_item.vpn0;
        endcase
    end

    assign w_slot      = {r_page, w_vpn};
    assign w_raddr     = w_slot;
    assign w_v         = r_rdata[0];
    assign w_leaf      = |r_rdata[3:1];
    assign w_child     = r_rdata[PTE_W-1:FLAG_W] - i_base_ppn;
    assign w_lvl_hi    = (r_level != 2'd0);
    assign w_is_map    = (r_item.op == OP_MAP);
    assign w_link_ok   = w_v && !w_leaf && (w_child < PPN_W'(TABLE_PAGES));
    assign w_can_alloc = !w_v && w_is_map && (r_nfp < NW'(TABLE_PAGES));
    assign w_fail      = !w_link_ok && !w_can_alloc;
    assign w_clr_last  = (r_clr_addr == AW'(DEPTH - 1));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: n_state = w_clr_last ? S_IDLE : S_CLEAR;
            S_IDLE: begin
                if (i_item_valid && (i_item.op != OP_REJECT)) begin
                    n_state = S_READ;
                end
            end
            S_READ: n_state = S_EVAL;
            S_EVAL: begin
                if (!w_lvl_hi) begin
                    n_state = S_IDLE;
                end else if (w_fail) begin
                    n_state = w_is_map ? S_ROLL : S_IDLE;
                end else begin
                    n_state = S_READ;
                end
            end
            S_ROLL: n_state = (r_made_v == 2'b00) ? S_IDLE : S_ROLL;
            default: n_state = S_IDLE;
        endcase
    end

    // datapath, memory write and result
    always_comb begin
        n_item      = r_item;
        n_level     = r_level;
        n_page      = r_page;
        n_nfp       = r_nfp;
        n_saved     = r_saved;
        n_made_v    = r_made_v;
        n_made_slot = r_made_slot;
        n_done      = 1'b0;
        n_status    = r_status;
        n_addr      = '0;
        w_we        = 1'b0;
        w_waddr     = w_slot;
        w_wdata     = '0;
        o_ctl.pop   = 1'b0;
        case (r_state)
            S_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr_addr;
            end
            S_IDLE: begin
                if (i_item_valid) begin
                    o_ctl.pop = 1'b1;
                    n_item    = i_item;
                    n_level   = 2'd2;
                    n_page    = '0;
                    n_saved   = r_nfp;
                    n_made_v  = 2'b00;
                    if (i_item.op == OP_REJECT) begin
                        n_done   = 1'b1;
                        n_status = ST_INVALID;
                    end
                end
            end
            S_EVAL: begin
                if (w_lvl_hi) begin
                    if (w_link_ok) begin
                        n_page  = w_child[PW-1:0];
                        n_level = r_level - 2'd1;
                    end else if (w_can_alloc) begin
                        // take a fresh table page and link it
                        w_we     = 1'b1;
                        w_wdata  = {i_base_ppn + PPN_W'(r_nfp), 7'd0, 1'b1};
                        n_made_v[r_level[1]]    = 1'b1;
                        n_made_slot[r_level[1]] = w_slot;
                        n_nfp   = r_nfp + NW'(1);
                        n_page  = r_nfp[PW-1:0];
                        n_level = r_level - 2'd1;
                    end else if (w_is_map) begin
                        n_nfp = r_saved;
                    end else begin
                        n_done   = 1'b1;
                        n_status = ST_NOT_MAPPED;
                    end
                end else begin
                    n_done = 1'b1;
                    case (r_item.op)
                        OP_TRANSLATE: begin
                            if (w_v && w_leaf) begin
                                n_status = ST_OK;
                                n_addr   = {r_rdata[PTE_W-1:FLAG_W], r_item.offset};
                            end else begin
                                n_status = ST_NOT_MAPPED;
                            end
                        end
                        OP_MAP: begin
                            if (w_v) begin
                                n_status = ST_EXISTS;
                            end else begin
                                w_we     = 1'b1;
                                w_wdata  = {r_item.ppn, r_item.flags};
                                n_status = ST_OK;
                            end
                        end
                        default: begin
                            if (w_v && w_leaf) begin
                                w_we     = 1'b1;
                                n_status = ST_OK;
                            end else begin
                                n_status = ST_NOT_MAPPED;
                            end
                        end
                    endcase
                end
            end
            S_ROLL: begin
                // clear links made by the failed map, one per cycle
                if (r_made_v[0]) begin
                    w_we        = 1'b1;
                    w_waddr     = r_made_slot[0];
                    n_made_v[0] = 1'b0;
                end else if (r_made_v[1]) begin
                    w_we        = 1'b1;
                    w_waddr     = r_made_slot[1];
                    n_made_v[1] = 1'b0;
                end else begin
                    n_done   = 1'b1;
                    n_status = ST_NO_MEMORY;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_ctl.clearing = (r_state == S_CLEAR);

    // pte memory, registered read
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[w_raddr];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_nfp      <= NW'(1);
            r_made_v   <= 2'b00;
            r_done     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= r_clr_addr + AW'(1);
            r_nfp      <= n_nfp;
            r_made_v   <= n_made_v;
            r_done     <= n_done;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_item      <= n_item;
        r_level     <= n_level;
        r_page      <= n_page;
        r_saved     <= n_saved;
        r_made_slot <= n_made_slot;
        r_status    <= n_status;
        r_addr      <= n_addr;
    end

    assign o_done            = r_done;
    assign o_status          = r_status;
    assign o_translated_addr = r_addr;

endmodule

FILE: rtl/sv39_page_table_engine_unit.sv
// top level of the sv39 page table engine
// After reset the pte memory is cleared entry by entry with busy high.
// A transaction is taken into a two-entry queue; the walker then answers a
// rejected command straight from the idle state, and a full walk takes a read
// state and an evaluation state per level on the pte memory's single read port;
// it undoes up to two new table links when a map cannot finish its walk.
// Results come on o_done for one cycle and cannot be held off.
`include "assert_macros.svh"

module sv39_page_table_engine_unit #(
    parameter int unsigned TABLE_PAGES = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [55:0]   i_cfg_wdata,
    input  logic          start,
    output logic          busy,
    input  logic [1:0]    i_command,
    input  logic [63:0]   i_virt_addr,
    input  logic [55:0]   i_phys_addr,
    input  logic [9:0]    i_pte_flags,
    output logic          o_done,
    output logic [2:0]    o_status,
    output logic [55:0]   o_translated_addr
);
    import sv39pte_pkg::*;

    logic      [55:0] r_table_base;
    t_back_ctl w_ctl;
    t_item     w_item;
    logic      w_item_valid;

    // table base register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_base <= '0;
        end else if (i_cfg_we) begin
            r_table_base <= i_cfg_wdata;
        end
    end

    sv39pte_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_command    (i_command),
        .i_virt_addr  (i_virt_addr),
        .i_phys_addr  (i_phys_addr),
        .i_pte_flags  (i_pte_flags),
        .i_ctl        (w_ctl),
        .o_item_valid (w_item_valid),
        .o_item       (w_item)
    );

    sv39pte_back #(
        .TABLE_PAGES (TABLE_PAGES)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_item_valid      (w_item_valid),
        .i_item            (w_item),
        .i_base_ppn        (r_table_base[55:12]),
        .o_ctl             (w_ctl),
        .o_done            (o_done),
        .o_status          (o_status),
        .o_translated_addr (o_translated_addr)
    );

    // checks
    `ASSERT_NEVER(a_no_done_in_clear, i_clk, i_rst_n, o_done && w_ctl.clearing)
    `ASSERT_IMPLY(a_addr_zero_on_fail, i_clk, i_rst_n, o_done && (o_status != ST_OK), o_translated_addr == '0)
    `ASSERT_IMPLY(a_status_known, i_clk, i_rst_n, o_done, o_status == ST_OK || o_status == ST_INVALID || o_status == ST_NO_MEMORY || o_status == ST_EXISTS || o_status == ST_NOT_MAPPED)
    `ASSERT_NEVER(a_no_pop_in_clear, i_clk, i_rst_n, w_ctl.pop && w_ctl.clearing)

endmodule

FILE: bench/sv39_page_table_engine_unit_tb.sv
// self-checking testbench of the sv39 page table engine unit
`timescale 1ns / 100ps

module sv39_page_table_engine_unit_tb;
    import sv39pte_pkg::*;

    localparam int unsigned TABLES     = 8;
    localparam int unsigned CYCLE_CAP  = 300000;
    localparam int unsigned SETTLE     = 40;
    localparam logic [1:0]  CMD_BAD    = 2'd3;
    localparam logic [7:0]  F_V        = 8'h01;

    typedef struct {
        logic [1:0]  cmd;
        logic [63:0] va;
        logic [55:0] pa;
        logic [9:0]  flags;
    } t_request;

    typedef struct {
        logic [2:0]  status;
        logic [55:0] addr;
    } t_answer;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_cfg_we = 1'b0;
    logic [55:0]   i_cfg_wdata = '0;
    logic          start = 1'b0;
    logic          busy;
    logic [1:0]    i_command = '0;
    logic [63:0]   i_virt_addr = '0;
    logic [55:0]   i_phys_addr = '0;
    logic [9:0]    i_pte_flags = '0;
    logic          o_done;
    logic [2:0]    o_status;
    logic [55:0]   o_translated_addr;

    t_request      pending_requests[$];
    t_answer       awaited_answers[$];
    t_request      on_port;
    bit            no_gaps = 1'b0;
    int unsigned   mismatches = 0;
    int unsigned   cycles = 0;

    // shadow page table
    logic [PTE_W-1:0] shadow_pte[TABLES*ENTRIES_PER_TABLE];
    int unsigned      shadow_free;
    logic [55:0]      shadow_base;

    sv39_page_table_engine_unit #(.TABLE_PAGES(TABLES)) uut (.*);

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) cycles <= cycles + 1;

    // run limit
    always @(posedge i_clk) begin
        if (cycles > CYCLE_CAP) begin
            $display("sv39_page_table_engine_unit_tb: FAIL");
            $finish;
        end
    end

    function automatic bit is_canon(logic [63:0] va);
        return (va[63:38] == '0) || (va[63:38] == '1);
    endfunction

    function automatic bit is_leaf_pte(logic [PTE_W-1:0] pte);
        return (pte[3:1] != 3'b000);
    endfunction

    // walk to the level-0 slot, allocating links for map and undoing them on failure
    function automatic bit walk_tables(logic [63:0] va, bit alloc, output int unsigned slot);
        logic [PPN_W-1:0] base_ppn;
        logic [PPN_W-1:0] child;
        logic [PTE_W-1:0] pte;
        int unsigned      saved;
        int unsigned      made[2];
        int unsigned      nmade;
        int unsigned      page;
        int unsigned      idx;
        bit               failed;
        base_ppn = shadow_base[55:12];
        saved = shadow_free;
        nmade = 0;
        page = 0;
        failed = 1'b0;
        slot = 0;
        for (int lvl = 2; lvl > 0; lvl--) begin
            idx = page * ENTRIES_PER_TABLE + 32'((va >> (12 + lvl * 9)) & 64'h1FF);
            pte = shadow_pte[idx];
            if (pte[0]) begin
                if (is_leaf_pte(pte)) begin
                    failed = 1'b1;
                    break;
                end
                child = pte[51:8] - base_ppn;
                if (child >= PPN_W'(TABLES)) begin
                    failed = 1'b1;
                    break;
                end
                page = 32'(child);
            end else if (!alloc || shadow_free >= TABLES) begin
                failed = 1'b1;
                break;
            end else begin
                shadow_pte[idx] = {base_ppn + PPN_W'(shadow_free), F_V};
                made[nmade] = idx;
                nmade++;
                page = shadow_free;
                shadow_free++;
            end
        end
        if (failed) begin
            while (nmade > 0) begin
                nmade--;
                shadow_pte[made[nmade]] = '0;
            end
            shadow_free = saved;
            return 1'b0;
        end
        slot = page * ENTRIES_PER_TABLE + 32'(va[20:12]);
        return 1'b1;
    endfunction

    function automatic bit flags_legal(logic [9:0] f);
        if (f[9:8] != 2'b00) return 1'b0;
        if (!f[0]) return 1'b0;
        if (!f[1] && !f[3]) return 1'b0;
        if (f[2] && !f[1]) return 1'b0;
        return 1'b1;
    endfunction

    // expected outcome of one command, updating the shadow table
    function automatic t_answer predict_answer(t_request rq);
        t_answer     ans;
        int unsigned slot;
        ans.status = ST_INVALID;
        ans.addr = '0;
        case (rq.cmd)
            CMD_TRANSLATE: begin
                if (!is_canon(rq.va)) ans.status = ST_INVALID;
                else if (!walk_tables(rq.va, 1'b0, slot) || !shadow_pte[slot][0] ||
                         !is_leaf_pte(shadow_pte[slot])) ans.status = ST_NOT_MAPPED;
                else begin
                    ans.status = ST_OK;
                    ans.addr = {shadow_pte[slot][51:8], rq.va[11:0]};
                end
            end
            CMD_MAP: begin
                if (!is_canon(rq.va) || rq.va[11:0] != 0 || rq.pa[11:0] != 0 ||
                    !flags_legal(rq.flags)) ans.status = ST_INVALID;
                else if (!walk_tables(rq.va, 1'b1, slot)) ans.status = ST_NO_MEMORY;
                else if (shadow_pte[slot][0]) ans.status = ST_EXISTS;
                else begin
                    shadow_pte[slot] = {rq.pa[55:12], rq.flags[7:0]};
                    ans.status = ST_OK;
                end
            end
            CMD_UNMAP: begin
                if (!is_canon(rq.va) || rq.va[11:0] != 0) ans.status = ST_INVALID;
                else if (!walk_tables(rq.va, 1'b0, slot) || !shadow_pte[slot][0] ||
                         !is_leaf_pte(shadow_pte[slot])) ans.status = ST_NOT_MAPPED;
                else begin
                    shadow_pte[slot] = '0;
                    ans.status = ST_OK;
                end
            end
            default: ans.status = ST_INVALID;
        endcase
        return ans;
    endfunction

    // driver: predict on acceptance, then present the next command or idle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) awaited_answers.push_back(predict_answer(on_port));
            if (!start || !busy) begin
                if (pending_requests.size() > 0 && (no_gaps || $urandom_range(99) >= 34)) begin
                    on_port = pending_requests.pop_front();
                    start <= 1'b1;
                    i_command <= on_port.cmd;
                    i_virt_addr <= on_port.va;
                    i_phys_addr <= on_port.pa;
                    i_pte_flags <= on_port.flags;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    task automatic report_mismatch(string what);
        $display("mismatch at cycle %0d: %s", cycles, what);
        mismatches++;
    endtask

    // monitor: compare each result with the oldest expectation
    always @(posedge i_clk) begin
        t_answer exp_ans;
        if (i_rst_n && o_done) begin
            if (awaited_answers.size() == 0) begin
                report_mismatch($sformatf("unexpected result status %0d", o_status));
            end else begin
                exp_ans = awaited_answers.pop_front();
                if (o_status !== exp_ans.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              o_status, exp_ans.status));
                if (o_translated_addr !== exp_ans.addr)
                    report_mismatch($sformatf("address %h, expected %h",
                                              o_translated_addr, exp_ans.addr));
            end
        end
    end

    task automatic add_request(logic [1:0] cmd, logic [63:0] va, logic [55:0] pa,
                               logic [9:0] flags);
        t_request rq;
        rq.cmd = cmd;
        rq.va = va;
        rq.pa = pa;
        rq.flags = flags;
        pending_requests.push_back(rq);
    endtask

    task automatic drain;
        while (pending_requests.size() > 0 || start || awaited_answers.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_base(logic [55:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        shadow_base = value;
        i_cfg_we <= 1'b0;
    endtask

    // va from a small pool so tables are shared and run out
    function automatic logic [63:0] pool_va();
        logic [8:0] v2;
        logic [8:0] v1;
        logic [8:0] v0;
        case ($urandom_range(2))
            0: v2 = 9'd0;
            1: v2 = 9'd1;
            default: v2 = 9'd511;
        endcase
        case ($urandom_range(2))
            0: v1 = 9'd0;
            1: v1 = 9'd5;
            default: v1 = 9'd511;
        endcase
        v0 = ($urandom_range(9) == 0) ? 9'($urandom) : 9'($urandom_range(7));
        return {{25{v2[8]}}, v2, v1, v0, 12'h000};
    endfunction

    function automatic logic [9:0] legal_flags();
        logic [9:0] f;
        f = 10'($urandom) & 10'h0F0;
        f[1] = 1'($urandom_range(1));
        f[3] = 1'($urandom_range(1));
        if (!f[1] && !f[3]) f[1] = 1'b1;
        f[2] = f[1] ? 1'($urandom_range(1)) : 1'b0;
        f[0] = 1'b1;
        return f;
    endfunction

    task automatic add_random(int unsigned count);
        logic [63:0] va;
        logic [55:0] pa;
        int unsigned pick;
        for (int unsigned n = 0; n < count; n++) begin
            va = pool_va();
            pa = 56'({$urandom, $urandom}) & 56'hFF_FFFF_FFFF_F000;
            pick = $urandom_range(99);
            if (pick < 45) add_request(CMD_MAP, va, pa, legal_flags());
            else if (pick < 75) add_request(CMD_TRANSLATE, va | 64'(12'($urandom)), pa,
                                            10'($urandom));
            else if (pick < 92) add_request(CMD_UNMAP, va, pa, 10'($urandom));
            else begin
                // malformed commands
                va = {$urandom, $urandom};
                case ($urandom_range(3))
                    0: begin
                        va[63] = ~va[38];
                        add_request(2'($urandom_range(2)), va, pa, legal_flags());
                    end
                    1: add_request(2'($urandom_range(1, 2)),
                                   pool_va() | 64'(12'($urandom_range(1, 4095))), pa,
                                   legal_flags());
                    2: add_request(CMD_MAP, pool_va(), 56'({$urandom, $urandom}),
                                   10'($urandom));
                    default: add_request(CMD_BAD, va, 56'({$urandom, $urandom}),
                                         10'($urandom));
                endcase
            end
        end
    endtask

    initial begin
        for (int i = 0; i < TABLES * ENTRIES_PER_TABLE; i++) shadow_pte[i] = '0;
        shadow_free = 1;
        shadow_base = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // memory clear pass
        while (busy) @(posedge i_clk);
        write_base(56'h0);

        // directed commands
        add_request(CMD_TRANSLATE, 64'h0, 56'h0, 10'h0);
        add_request(CMD_MAP, 64'h0, 56'hFF_FFFF_FFFF_F000, 10'h0FF);
        add_request(CMD_TRANSLATE, 64'hFFF, 56'h0, 10'h0);
        add_request(CMD_MAP, 64'h0, 56'h1000, 10'h00B);
        add_request(CMD_UNMAP, 64'h0, 56'h0, 10'h0);
        add_request(CMD_UNMAP, 64'h0, 56'h0, 10'h0);
        add_request(CMD_MAP, 64'hFFFF_FFFF_FFFF_F000, 56'h0, 10'h00F);
        add_request(CMD_TRANSLATE, 64'hFFFF_FFFF_FFFF_FFFF, 56'h0, 10'h3FF);
        add_request(CMD_TRANSLATE, 64'h0000_0040_0000_0000, 56'h0, 10'h0);
        add_request(CMD_MAP, 64'h8000_0000_0000_0000, 56'h0, 10'h003);
        add_request(CMD_UNMAP, 64'h7FFF_FFC0_0000_0000, 56'h0, 10'h0);
        add_request(CMD_MAP, 64'h2001, 56'h0, 10'h003);
        add_request(CMD_UNMAP, 64'hFFFF_FFFF_FFFF_F800, 56'h0, 10'h0);
        add_request(CMD_MAP, 64'h2000, 56'h800, 10'h003);
        add_request(CMD_MAP, 64'h2000, 56'h0, 10'h103);
        add_request(CMD_MAP, 64'h2000, 56'h0, 10'h203);
        add_request(CMD_MAP, 64'h2000, 56'h0, 10'h00E);
        add_request(CMD_MAP, 64'h2000, 56'h0, 10'h0F5);
        add_request(CMD_MAP, 64'h2000, 56'h0, 10'h005);
        add_request(CMD_MAP, 64'h2000, 56'h5000, 10'h007);
        add_request(CMD_BAD, 64'h2000, 56'h5000, 10'h007);
        add_request(CMD_TRANSLATE, 64'h2ABC, 56'h0, 10'h0);
        drain();

        // random phases over several table bases
        add_random(180);
        drain();
        write_base(56'h00_0000_0000_1000);
        no_gaps = 1'b1;
        add_random(170);
        drain();
        no_gaps = 1'b0;
        write_base(56'h00_0000_0000_2FFF);
        add_random(170);
        drain();
        write_base(56'hFF_FFFF_FFFF_FFFF);
        add_random(170);
        drain();
        write_base(56'({$urandom, $urandom}));
        add_random(170);
        drain();
        write_base(56'h0);
        add_random(170);
        drain();

        if (mismatches == 0) $display("sv39_page_table_engine_unit_tb: PASS");
        else $display("sv39_page_table_engine_unit_tb: FAIL");
        $finish;
    end

endmodule
